@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the polygon point inclusion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PPI_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PPI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

@@ rtl/ppi_pkg.sv @@
// Package with types and constants of the polygon point inclusion block.
`timescale 1ns / 1ps

package ppi_pkg;

  localparam int COORD_W = 24;           // coordinate width, 8 fraction bits
  localparam int REL_W   = COORD_W + 1;  // coordinate relative to the origin
  localparam int DIFF_W  = COORD_W + 2;  // point minus vertex offset
  localparam int PROD_W  = DIFF_W + REL_W;
  localparam int CNT_OUT_W = 5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 1'b1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic                 inside_res;
    logic                 status;
    logic [CNT_OUT_W-1:0] vertex_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic load;     // take the appended vertex
    logic shift;    // take the neighbor's vertex
    logic is_last;  // last occupied cell, wraps to the head
  } cell_ctl_t;

  typedef struct packed {
    logic busy;     // an edge is still in the pipeline
    logic flip;     // the retiring edge crosses left of the point
  } edge_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } ppi_state_t;

endpackage

@@ rtl/ppi_cell.sv @@
// One vertex cell of the rotating vertex chain.
`timescale 1ns / 1ps

module ppi_cell (
  input  logic               clk,
  input  ppi_pkg::cell_ctl_t ctl,
  input  ppi_pkg::vertex_t   ld_vtx,
  input  ppi_pkg::vertex_t   nbr_vtx,
  input  ppi_pkg::vertex_t   head_vtx,
  output ppi_pkg::vertex_t   vtx
);
  import ppi_pkg::*;

  vertex_t vtx_r;
  vertex_t vtx_nxt;

  // The last occupied cell closes the ring by taking the head's vertex.
  always_comb begin
    vtx_nxt = vtx_r;
    if (ctl.load) begin
      vtx_nxt = ld_vtx;
    end else if (ctl.shift) begin
      vtx_nxt = ctl.is_last ? head_vtx : nbr_vtx;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt;
  end

  assign vtx = vtx_r;

endmodule

@@ rtl/ppi_edge.sv @@
// Pipelined edge crossing test: differences, products, then the compare.
`timescale 1ns / 1ps

module ppi_edge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  ppi_pkg::vertex_t                   cur,
  input  ppi_pkg::vertex_t                   prv,
  input  logic signed [ppi_pkg::REL_W-1:0]   rpx,
  input  logic signed [ppi_pkg::REL_W-1:0]   rpy,
  output ppi_pkg::edge_stat_t                stat
);
  import ppi_pkg::*;

  logic signed [REL_W-1:0]  yi, yj, xi, xj;
  logic                     straddle;
  logic                     xcond;

  logic                     s1_vld_r, s1_vld_nxt;
  logic                     s1_act_r, s1_act_nxt;
  logic                     s1_dypos_r, s1_dypos_nxt;
  logic signed [REL_W-1:0]  s1_dxji_r, s1_dxji_nxt;
  logic signed [REL_W-1:0]  s1_dy_r, s1_dy_nxt;
  logic signed [DIFF_W-1:0] s1_dyp_r, s1_dyp_nxt;
  logic signed [DIFF_W-1:0] s1_dxp_r, s1_dxp_nxt;

  logic                     s2_vld_r;
  logic                     s2_act_r;
  logic                     s2_dypos_r;
  logic signed [PROD_W-1:0] s2_lhs_r, s2_lhs_nxt;
  logic signed [PROD_W-1:0] s2_rhs_r, s2_rhs_nxt;
  logic                     left;

  // Vertex offsets are compared against the point taken relative to the origin,
  // which gives the same answers as absolute coordinates.
  assign xi = REL_W'(cur.x);
  assign yi = REL_W'(cur.y);
  assign xj = REL_W'(prv.x);
  assign yj = REL_W'(prv.y);

  assign straddle = ((yi < rpy) && (yj >= rpy)) || ((yj < rpy) && (yi >= rpy));
  assign xcond    = (xi <= rpx) || (xj <= rpx);

  assign s1_vld_nxt   = in_vld;
  assign s1_act_nxt   = straddle && xcond;
  assign s1_dypos_nxt = yj > yi;
  assign s1_dxji_nxt  = xj - xi;
  assign s1_dy_nxt    = yj - yi;
  assign s1_dyp_nxt   = DIFF_W'(rpy) - DIFF_W'(yi);
  assign s1_dxp_nxt   = DIFF_W'(rpx) - DIFF_W'(xi);

  assign s2_lhs_nxt = PROD_W'(s1_dyp_r) * PROD_W'(s1_dxji_r);
  assign s2_rhs_nxt = PROD_W'(s1_dxp_r) * PROD_W'(s1_dy_r);

  // The sense of the compare flips unless the previous vertex lies above the current one.
  assign left = s2_dypos_r ? (s2_lhs_r < s2_rhs_r) : (s2_lhs_r > s2_rhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_act_r   <= s1_act_nxt;
    s1_dypos_r <= s1_dypos_nxt;
    s1_dxji_r  <= s1_dxji_nxt;
    s1_dy_r    <= s1_dy_nxt;
    s1_dyp_r   <= s1_dyp_nxt;
    s1_dxp_r   <= s1_dxp_nxt;
    s2_act_r   <= s1_act_r;
    s2_dypos_r <= s1_dypos_r;
    s2_lhs_r   <= s2_lhs_nxt;
    s2_rhs_r   <= s2_rhs_nxt;
  end

  assign stat.busy = s1_vld_r || s2_vld_r;
  assign stat.flip = s2_vld_r && s2_act_r && left;

endmodule

@@ rtl/polygon_point_inclusion.sv @@
// Top level of the polygon point inclusion block (even-odd crossing rule).
`timescale 1ns / 1ps

// Channel   Direction  Transfer when            Payload
// in_       input      in_valid && !in_stall    op, x_coord, y_coord
// out_      output     out_valid && !out_stall  inside_res, status, vertex_count
// cfg_      input      cfg_we                   pos_x or pos_y by cfg_index
//
// A clear, an append or a test of an empty polygon goes straight to the output
// register. A test of a nonempty polygon first primes the chain, then issues one
// edge per vertex while the vertex ring rotates past the head cell, then drains
// the edge pipeline and finally loads the result. Reset is synchronous and
// empties the polygon; the origin returns to zero. One item is in work at a
// time, and a result held in the output register stalls the input for as long
// as the receiver stalls that result.

module polygon_point_inclusion #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ppi_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppi_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ppi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppi_pkg::COORD_W-1:0]   cfg_data
);
  import ppi_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Configuration registers hold the polygon origin.
  logic signed [COORD_W-1:0] pos_x_r;
  logic signed [COORD_W-1:0] pos_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POS_X: pos_x_r <= cfg_data;
        CFG_POS_Y: pos_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ppi_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             parity_r, parity_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  vertex_t          prev_r, prev_nxt;
  logic signed [REL_W-1:0] rpx_r, rpx_nxt;
  logic signed [REL_W-1:0] rpy_r, rpy_nxt;

  logic             in_xfer;
  logic             out_free;
  logic             do_append;
  logic             do_shift;
  logic             edge_vld;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;
  edge_stat_t       estat;

  vertex_t   vtx [MAX_VERTICES];
  cell_ctl_t ctl [MAX_VERTICES];
  vertex_t   ld_vtx;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign last_idx = count_r - CNT_W'(1);

  assign ld_vtx.x = in_data.x_coord;
  assign ld_vtx.y = in_data.y_coord;
  assign do_append = in_xfer && (in_data.op == OP_APPEND) &&
                     (count_r < CNT_W'(MAX_VERTICES));

  // The vertex ring: cell k holds vertex k at rest. A test rotates the ring
  // toward cell 0 so that the head cell shows one vertex after another, and
  // after n rotations every vertex is back in its own cell.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    localparam int NBR = (k + 1 < MAX_VERTICES) ? k + 1 : 0;

    assign ctl[k].load    = do_append && (count_r == CNT_W'(k));
    assign ctl[k].shift   = do_shift;
    assign ctl[k].is_last = (last_idx == CNT_W'(k));

    ppi_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[k]),
      .ld_vtx   (ld_vtx),
      .nbr_vtx  (vtx[NBR]),
      .head_vtx (vtx[0]),
      .vtx      (vtx[k])
    );
  end

  ppi_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (edge_vld),
    .cur    (vtx[0]),
    .prv    (prev_r),
    .rpx    (rpx_r),
    .rpy    (rpy_r),
    .stat   (estat)
  );

  assign count_ext = {{CNT_OUT_W{1'b0}}, count_nxt};

  // Sequencer. Items that finish at once go straight to the output register;
  // a test of a nonempty polygon walks the ring, one edge a cycle.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    parity_nxt    = parity_r ^ estat.flip;
    prev_nxt      = prev_r;
    rpx_nxt       = rpx_r;
    rpy_nxt       = rpy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    do_shift      = 1'b0;
    edge_vld      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          out_data_nxt.inside_res = 1'b0;
          out_data_nxt.status     = 1'b0;
          unique case (in_data.op)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (do_append) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                out_data_nxt.status = 1'b1;
              end
            end
            OP_TEST: begin
              rpx_nxt    = REL_W'(in_data.x_coord) - REL_W'(pos_x_r);
              rpy_nxt    = REL_W'(in_data.y_coord) - REL_W'(pos_y_r);
              parity_nxt = 1'b0;
            end
            default: ;
          endcase
          out_data_nxt.vertex_count = count_ext[CNT_OUT_W-1:0];
          if ((in_data.op == OP_TEST) && (count_r != '0)) begin
            state_nxt = ST_LOAD;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        prev_nxt  = vtx[0];
        do_shift  = 1'b1;
        step_nxt  = CNT_W'(1);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        edge_vld = 1'b1;
        prev_nxt = vtx[0];
        if (step_r < count_r) begin
          do_shift = 1'b1;
          step_nxt = step_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!estat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_nxt.inside_res   = parity_r;
          out_data_nxt.status       = 1'b0;
          out_data_nxt.vertex_count = count_ext[CNT_OUT_W-1:0];
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    parity_r   <= parity_nxt;
    prev_r     <= prev_nxt;
    rpx_r      <= rpx_nxt;
    rpy_r      <= rpy_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A test of a nonempty polygon always starts by priming the ring.
  `PPI_ASSERT_NEXT(a_test_primes, clk, rst_n,
    in_xfer && (in_data.op == OP_TEST) && (count_r != '0), state_r == ST_LOAD)
  // The edge pipeline is empty whenever the block can take a new item.
  `PPI_ASSERT_NOW(a_idle_drained, clk, rst_n, state_r == ST_IDLE, !estat.busy)
  // The walk never issues more edges than there are vertices.
  `PPI_ASSERT_NOW(a_walk_bound, clk, rst_n, state_r == ST_WALK,
    (step_r != '0) && (step_r <= count_r))
  // The store never holds more vertices than it has cells.
  `PPI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_VERTICES))

endmodule
